/* sv/sdspi_pkg.sv */
// Package for the SD SPI-mode command engine: request and result structs,
// byte constants, command codes, register indexes and the frame byte function.
// No dependencies.
package sdspi_pkg;

  typedef struct packed {
    logic        operation;
    logic [5:0]  command_index;
    logic [31:0] argument;
    logic [7:0]  rx_byte;
  } sdspi_in_t;

  typedef struct packed {
    logic       slot_request;
    logic [7:0] tx_byte;
    logic       card_select;
    logic       done_res;
    logic       failed;
    logic       data_follows;
  } sdspi_out_t;

  localparam logic       OP_START = 1'b0;
  localparam logic       OP_SLOT  = 1'b1;

  localparam logic [5:0] CMD_RESET      = 6'd0;
  localparam logic [5:0] CMD_READ_BLOCK = 6'd17;

  localparam logic [7:0] BYTE_IDLE       = 8'hff;
  localparam logic [7:0] BYTE_CRC_RESET  = 8'h95;
  localparam logic [7:0] BYTE_CMD_MARK   = 8'h40;
  localparam logic [7:0] BYTE_TOKEN      = 8'hfe;
  localparam logic [7:0] BYTE_R1_IDLE    = 8'h01;
  localparam logic [7:0] BYTE_R1_READY   = 8'h00;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_PREAMBLE_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POLL_LIMIT      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ATTEMPT_LIMIT   = 2'd2;

  localparam logic [9:0]  PREAMBLE_RESET = 10'd300;
  localparam logic [15:0] POLL_RESET     = 16'd1000;
  localparam logic [3:0]  ATTEMPT_RESET  = 4'd5;
  localparam logic [3:0]  ATTEMPT_MAX    = 4'd15;
  localparam logic [2:0]  FRAME_LAST     = 3'd5;

  // Byte i of a six-byte command frame: command, argument MSB first, then the CRC byte (0x95 for reset, else 0xff).
  function automatic logic [7:0] frame_byte(input logic [5:0] cmd,
                                            input logic [31:0] arg,
                                            input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = {2'b00, cmd} | BYTE_CMD_MARK;
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = (cmd == CMD_RESET) ? BYTE_CRC_RESET : BYTE_IDLE;
    endcase
    return b;
  endfunction

endpackage

/* sv/sd_spi_command_engine.sv */
// SD/MMC SPI-mode command engine, top level.
// Depends on sdspi_pkg for payload structs, constants and frame_byte().

// Runs one SPI-mode command, one byte exchange per request. A start request
// latches the command index and argument; each following slot request reports
// the byte received in the exchange just finished, and every request yields
// exactly one result telling the byte controller whether to exchange another
// byte (and which one), the chip-select level, and on completion whether the
// command failed or whether block data follows with the card left selected.
// A reset command (index 0) is preceded by preamble_length 0xff bytes with
// the card deselected; R1 is polled for up to poll_limit reads plus one
// discarded read on timeout; a failed attempt is retried until attempt_limit
// attempts have been made. The block has a request register and a result
// register with all decision logic between them: a request is accepted every
// cycle, and its result is computed from the request register and written
// to the result register, so requests stream back to back while results are
// taken. A result that waits for out_ready holds the request behind it in the
// request register, and in_ready stays low until the result is taken. In use
// the rate is set by the SPI byte exchange. Configuration writes take effect at
// once and must be made while no command is in progress.
module sd_spi_command_engine
  import sdspi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sdspi_in_t              in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sdspi_out_t             out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PREAMBLE,
    PH_FRAME,
    PH_RESP,
    PH_TOKEN,
    PH_TRAIL_OK,
    PH_TRAIL_FAIL
  } phase_t;

  // Configuration registers.
  logic [9:0]  preamble_length;
  logic [15:0] poll_limit;
  logic [3:0]  attempt_limit;

  // Request register.
  logic      req_valid;
  sdspi_in_t req;

  // Command state.
  phase_t      phase, phase_next;
  logic [3:0]  attempt_count, attempt_count_next;
  logic [15:0] poll_count, poll_count_next;
  logic [2:0]  frame_byte_index, frame_byte_index_next;
  logic [9:0]  preamble_count, preamble_count_next;
  logic [5:0]  held_command, held_command_next;
  logic [31:0] held_argument, held_argument_next;
  logic        select_level, select_level_next;

  // Result register.
  sdspi_out_t res, res_next;
  logic       res_valid;

  logic fire;
  logic launch;
  logic frame_go;
  logic poll_timeout;
  logic poll_hit;
  logic [7:0] expect_byte;
  logic [3:0] attempt_inc;

  // The request is processed when the result register is free or draining.
  assign fire     = req_valid && (!res_valid || out_ready);
  assign in_ready = !req_valid || fire;

  assign out_valid = res_valid;
  assign out_data  = res;

  // A poll times out once poll_limit reads have missed; the read that
  // arrives then is discarded whatever it holds.
  assign expect_byte  = (phase == PH_TOKEN) ? BYTE_TOKEN :
                        (held_command == CMD_RESET) ? BYTE_R1_IDLE : BYTE_R1_READY;
  assign poll_timeout = poll_count >= poll_limit;
  assign poll_hit     = req.rx_byte == expect_byte;
  assign attempt_inc  = (attempt_count < ATTEMPT_MAX) ? attempt_count + 4'd1
                                                       : attempt_count;

  always_comb begin
    phase_next            = phase;
    attempt_count_next    = attempt_count;
    poll_count_next       = poll_count;
    frame_byte_index_next = frame_byte_index;
    preamble_count_next   = preamble_count;
    held_command_next     = held_command;
    held_argument_next    = held_argument;
    select_level_next     = select_level;
    launch                = 1'b0;
    frame_go              = 1'b0;
    res_next              = '0;

    if (req.operation == OP_START) begin
      // A start aborts whatever is running and begins a fresh command.
      held_command_next  = req.command_index;
      held_argument_next = req.argument;
      attempt_count_next = '0;
      launch             = 1'b1;
    end else begin
      unique case (phase)
        PH_PREAMBLE: begin
          if (preamble_count < preamble_length) begin
            preamble_count_next  = preamble_count + 10'd1;
            res_next.slot_request = 1'b1;
            res_next.tx_byte      = BYTE_IDLE;
          end else begin
            frame_go = 1'b1;
          end
        end
        PH_FRAME: begin
          if (frame_byte_index < FRAME_LAST) begin
            frame_byte_index_next = frame_byte_index + 3'd1;
            res_next.slot_request = 1'b1;
            res_next.tx_byte      = frame_byte(held_command, held_argument,
                                                frame_byte_index + 3'd1);
          end else begin
            phase_next            = PH_RESP;
            poll_count_next       = '0;
            res_next.slot_request = 1'b1;
            res_next.tx_byte      = BYTE_IDLE;
          end
        end
        PH_RESP, PH_TOKEN: begin
          res_next.slot_request = 1'b1;
          res_next.tx_byte      = BYTE_IDLE;
          if (poll_timeout) begin
            select_level_next = 1'b0;
            phase_next        = PH_TRAIL_FAIL;
          end else if (!poll_hit) begin
            poll_count_next = poll_count + 16'd1;
          end else if (phase == PH_TOKEN) begin
            // Start token found: the card stays selected for the data.
            phase_next            = PH_IDLE;
            res_next.slot_request = 1'b0;
            res_next.tx_byte      = '0;
            res_next.done_res     = 1'b1;
            res_next.data_follows = 1'b1;
          end else if (held_command == CMD_READ_BLOCK) begin
            phase_next      = PH_TOKEN;
            poll_count_next = '0;
          end else begin
            select_level_next = 1'b0;
            phase_next        = PH_TRAIL_OK;
          end
        end
        PH_TRAIL_OK, PH_TRAIL_FAIL: begin
          attempt_count_next = attempt_inc;
          if (phase == PH_TRAIL_OK) begin
            phase_next        = PH_IDLE;
            res_next.done_res = 1'b1;
          end else if (attempt_inc < attempt_limit) begin
            launch = 1'b1;
          end else begin
            phase_next        = PH_IDLE;
            res_next.done_res = 1'b1;
            res_next.failed   = 1'b1;
          end
        end
        default: begin
          // Slot while idle is ignored.
          phase_next = PH_IDLE;
        end
      endcase
    end

    // Begin an attempt: reset commands get the deselected preamble first.
    if (launch) begin
      if (held_command_next == CMD_RESET) begin
        select_level_next = 1'b0;
        if (preamble_length != '0) begin
          phase_next            = PH_PREAMBLE;
          preamble_count_next   = 10'd1;
          res_next.slot_request = 1'b1;
          res_next.tx_byte      = BYTE_IDLE;
        end else begin
          frame_go = 1'b1;
        end
      end else begin
        frame_go = 1'b1;
      end
    end

    // Select the card and send the first frame byte.
    if (frame_go) begin
      select_level_next     = 1'b1;
      phase_next            = PH_FRAME;
      frame_byte_index_next = '0;
      res_next.slot_request = 1'b1;
      res_next.tx_byte      = frame_byte(held_command_next, held_argument_next, 3'd0);
    end

    res_next.card_select = select_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_length  <= PREAMBLE_RESET;
      poll_limit       <= POLL_RESET;
      attempt_limit    <= ATTEMPT_RESET;
      req_valid        <= 1'b0;
      res_valid        <= 1'b0;
      phase            <= PH_IDLE;
      attempt_count    <= '0;
      poll_count       <= '0;
      frame_byte_index <= '0;
      preamble_count   <= '0;
      held_command     <= '0;
      held_argument    <= '0;
      select_level     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PREAMBLE_LENGTH: preamble_length <= cfg_data[9:0];
          CFG_POLL_LIMIT:      poll_limit      <= cfg_data;
          CFG_ATTEMPT_LIMIT:   attempt_limit   <= cfg_data[3:0];
          default:             ;
        endcase
      end

      if (in_ready) begin
        req_valid <= in_valid;
      end

      if (fire) begin
        res_valid        <= 1'b1;
        phase            <= phase_next;
        attempt_count    <= attempt_count_next;
        poll_count       <= poll_count_next;
        frame_byte_index <= frame_byte_index_next;
        preamble_count   <= preamble_count_next;
        held_command     <= held_command_next;
        held_argument    <= held_argument_next;
        select_level     <= select_level_next;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
    if (fire) begin
      res <= res_next;
    end
  end

endmodule
